// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SSET_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Condition must never be seen outside reset.
`define SSET_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/sset_pkg.sv =====
// Package: widths, codes, reset values and cell control type of the generator.
`default_nettype none

package sset_pkg;

  // Widths fixed by the interface
  localparam int FIELD_BITS_DEF = 16;
  localparam int EXP_W          = 5;
  localparam int POS_W          = 33;
  localparam int START_W        = 16;
  localparam int CFG_DATA_W     = 33;
  localparam int CFG_IDX_W      = 3;
  localparam int NUM_CELLS      = 3;

  // Register reset values (wide, part-selected to the field width)
  localparam logic [EXP_W-1:0] FIELD_EXP_RST  = 5'd16;
  localparam logic [63:0]      FIELD_POLY_RST = 64'd65581;
  localparam logic [63:0]      COEF_C2_RST    = 64'd0;
  localparam logic [63:0]      COEF_C1_RST    = 64'd1;
  localparam logic [63:0]      COEF_C0_RST    = 64'd1;
  localparam logic [POS_W-1:0] END_INDEX_RST  = 33'd4295032833;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_EXP  = 3'd0,
    REG_FIELD_POLY = 3'd1,
    REG_COEF_C2    = 3'd2,
    REG_COEF_C1    = 3'd3,
    REG_COEF_C0    = 3'd4,
    REG_END_INDEX  = 3'd5
  } cfg_reg_t;

  // Request action codes
  typedef enum logic {
    ACT_RESTART = 1'b0,
    ACT_STEP    = 1'b1
  } action_t;

  // Control handed to every cell
  typedef struct packed {
    logic load;
    logic step;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sset_cell.sv =====
// One recurrence cell: holds one GF(2^n) coefficient, multiplies feedback by its constant.
`default_nettype none

module sset_cell #(
  parameter int                    FIELD_BITS  = sset_pkg::FIELD_BITS_DEF,
  parameter logic [FIELD_BITS-1:0] RESET_VALUE = '0
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire  sset_pkg::cell_ctrl_t ctrl,
  input  wire  [FIELD_BITS-1:0] carry_in,
  input  wire  [FIELD_BITS-1:0] fb,
  input  wire  [FIELD_BITS-1:0] coef,
  input  wire  [FIELD_BITS-1:0] load_val,
  input  wire  [FIELD_BITS-1:0] elem_mask,
  input  wire  [FIELD_BITS-1:0] red_poly,
  input  wire  [FIELD_BITS-1:0] top_bit,
  output logic [FIELD_BITS-1:0] value
);

  import sset_pkg::*;

  logic [FIELD_BITS-1:0] prod;
  logic [FIELD_BITS-1:0] value_next;

  // Shift-and-add multiply, reducing as the multiplicand is shifted up
  function automatic logic [FIELD_BITS-1:0] gf_mul(
    input logic [FIELD_BITS-1:0] a_in,
    input logic [FIELD_BITS-1:0] b_in,
    input logic [FIELD_BITS-1:0] m,
    input logic [FIELD_BITS-1:0] red,
    input logic [FIELD_BITS-1:0] top
  );
    logic [FIELD_BITS-1:0] a;
    logic [FIELD_BITS-1:0] b;
    logic [FIELD_BITS-1:0] acc;
    a   = a_in & m;
    b   = b_in & m;
    acc = '0;
    for (int i = 0; i < FIELD_BITS; i++) begin
      if (b[i]) acc = acc ^ a;
      if ((a & top) != '0) a = ((a << 1) & m) ^ red;
      else a = (a << 1) & m;
    end
    return acc & m;
  endfunction

  assign prod = gf_mul(fb, coef, elem_mask, red_poly, top_bit);

  // Next coefficient: load, step or hold
  always_comb begin
    value_next = value;
    if (ctrl.load) begin
      value_next = load_val & elem_mask;
    end else if (ctrl.step) begin
      value_next = ((carry_in & elem_mask) ^ prod) & elem_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= RESET_VALUE;
    end else begin
      value <= value_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sset_out_buf.sv =====
// Two-entry output buffer that decouples result delivery from request intake.
`default_nettype none

module sset_out_buf #(
  parameter int DATA_W = sset_pkg::POS_W
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  wire  [DATA_W-1:0] push_data,
  output logic              full,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [DATA_W-1:0] out_data
);

  import sset_pkg::*;

  logic [DATA_W-1:0] head;
  logic [DATA_W-1:0] tail;
  logic [1:0]        count;
  logic              pop;

  assign pop       = out_valid & ~out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = head;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Data entries
  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) head <= push_data;
      else tail <= push_data;
    end else if (pop && !push) begin
      head <= tail;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        head <= push_data;
      end else begin
        head <= tail;
        tail <= push_data;
      end
    end
  end

  `include "assert_macros.svh"

  `SSET_NEVER(a_count_range, clk, rst, count == 2'd3, "output buffer count out of range")
  `SSET_NEVER(a_push_when_full, clk, rst, push && count == 2'd2, "result pushed into full buffer")
  `SSET_ASSERT(a_drain_from_full, clk, rst, (!rst && pop && !push && count == 2'd2) |=> count == 2'd1, "buffer did not drain")

endmodule

`default_nettype wire

// ===== rtl/singer_set_recurrence_generator_core.sv =====
// Singer difference set generator: a restart request loads the start vector and
// position; each step request, while the position is below end_index, emits the
// position when the high coefficient is zero and advances the GF(2^n) recurrence
// through a row of three cells (low, mid, high), each one multiply by its cubic
// coefficient plus an XOR with its lower neighbor. One request is taken per clock;
// a step completes in that cycle's cell update, and its result is registered in a
// two-entry buffer before it reaches the output; the buffer stalls intake only
// when both of its entries are waiting.
`default_nettype none

module singer_set_recurrence_generator_core #(
  parameter int FIELD_BITS = sset_pkg::FIELD_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  // request channel
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             action,
  input  wire  [sset_pkg::POS_W-1:0]      start_index,
  input  wire  [sset_pkg::START_W-1:0]    start_high,
  input  wire  [sset_pkg::START_W-1:0]    start_mid,
  input  wire  [sset_pkg::START_W-1:0]    start_low,
  // result channel
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [sset_pkg::POS_W-1:0]      element_index,
  // configuration
  input  wire                             cfg_write,
  input  wire  [sset_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [sset_pkg::CFG_DATA_W-1:0] cfg_data
);

  import sset_pkg::*;

  // Configuration registers
  logic [EXP_W-1:0]      field_exp;
  logic [FIELD_BITS-1:0] field_poly;
  logic [FIELD_BITS-1:0] coef_c2;
  logic [FIELD_BITS-1:0] coef_c1;
  logic [FIELD_BITS-1:0] coef_c0;
  logic [POS_W-1:0]      end_index;

  // Field derived values
  logic [EXP_W-1:0]      n_eff;
  logic [FIELD_BITS-1:0] elem_mask;
  logic [FIELD_BITS-1:0] top_bit;
  logic [FIELD_BITS-1:0] red_poly;

  // Datapath
  logic [POS_W-1:0]      position;
  logic [FIELD_BITS-1:0] vec       [NUM_CELLS];
  logic [FIELD_BITS-1:0] coefs     [NUM_CELLS];
  logic [FIELD_BITS-1:0] starts    [NUM_CELLS];
  logic [FIELD_BITS-1:0] fb;
  logic                  in_acc;
  logic                  in_live;
  logic                  load_go;
  logic                  step_go;
  logic                  emit;
  cell_ctrl_t            ctrl;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      field_exp  <= FIELD_EXP_RST;
      field_poly <= FIELD_POLY_RST[FIELD_BITS-1:0];
      coef_c2    <= COEF_C2_RST[FIELD_BITS-1:0];
      coef_c1    <= COEF_C1_RST[FIELD_BITS-1:0];
      coef_c0    <= COEF_C0_RST[FIELD_BITS-1:0];
      end_index  <= END_INDEX_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FIELD_EXP:  field_exp  <= cfg_data[EXP_W-1:0];
        REG_FIELD_POLY: field_poly <= cfg_data[FIELD_BITS-1:0];
        REG_COEF_C2:    coef_c2    <= cfg_data[FIELD_BITS-1:0];
        REG_COEF_C1:    coef_c1    <= cfg_data[FIELD_BITS-1:0];
        REG_COEF_C0:    coef_c0    <= cfg_data[FIELD_BITS-1:0];
        REG_END_INDEX:  end_index  <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Degree clamp, element mask, top bit and reduction bits
  always_comb begin
    n_eff = field_exp;
    if (field_exp == '0) n_eff = EXP_W'(1);
    else if (field_exp > EXP_W'(FIELD_BITS)) n_eff = EXP_W'(FIELD_BITS);
    for (int i = 0; i < FIELD_BITS; i++) begin
      elem_mask[i] = (EXP_W'(i) < n_eff);
      top_bit[i]   = (EXP_W'(i + 1) == n_eff);
    end
    red_poly = field_poly & elem_mask;
  end

  // Request decode
  assign in_acc    = in_valid & ~in_stall;
  assign in_live   = (position < end_index);
  assign load_go   = in_acc & (action_t'(action) == ACT_RESTART);
  assign step_go   = in_acc & (action_t'(action) == ACT_STEP) & in_live;
  assign fb        = vec[NUM_CELLS-1] & elem_mask;
  assign emit      = step_go & (fb == '0);
  assign ctrl.load = load_go;
  assign ctrl.step = step_go;

  // Cell inputs, low cell first
  assign coefs[0]  = coef_c0;
  assign coefs[1]  = coef_c1;
  assign coefs[2]  = coef_c2;
  assign starts[0] = FIELD_BITS'(start_low);
  assign starts[1] = FIELD_BITS'(start_mid);
  assign starts[2] = FIELD_BITS'(start_high);

  // Row of cells: each above the low cell takes its lower neighbor; all take the high feedback
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    logic [FIELD_BITS-1:0] carry;
    if (k == 0) begin : g_first
      assign carry = '0;
    end else begin : g_next
      assign carry = vec[k-1];
    end

    sset_cell #(
      .FIELD_BITS  (FIELD_BITS),
      .RESET_VALUE ((k == 0) ? FIELD_BITS'(1) : FIELD_BITS'(0))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .carry_in  (carry),
      .fb        (fb),
      .coef      (coefs[k]),
      .load_val  (starts[k]),
      .elem_mask (elem_mask),
      .red_poly  (red_poly),
      .top_bit   (top_bit),
      .value     (vec[k])
    );
  end

  // Position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (load_go) begin
      position <= start_index;
    end else if (step_go) begin
      position <= position + POS_W'(1);
    end
  end

  // Result buffer
  sset_out_buf #(
    .DATA_W (POS_W)
  ) u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (position),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (element_index)
  );

  `include "assert_macros.svh"

  `SSET_ASSERT(a_restart_pos, clk, rst, (!rst && load_go) |=> position == $past(start_index), "restart did not load position")
  `SSET_ASSERT(a_step_advance, clk, rst, (!rst && step_go) |=> position == $past(position) + POS_W'(1), "step did not advance position")
  `SSET_ASSERT(a_end_holds, clk, rst, (!rst && in_acc && action == ACT_STEP && !in_live) |=> $stable(position), "step past end moved position")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the Singer difference set generator core.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sset_pkg::*;

  localparam int FB         = FIELD_BITS_DEF;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 100;
  localparam int HOLD_PHASE = 2;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_PAD  = 8;
  localparam int STUCK_MAX  = 2000;

  // Tracks the generator state and the set elements still owed by the block
  class element_scoreboard;
    logic [EXP_W-1:0]   field_exp;
    logic [FB:0]        field_poly;
    logic [FB-1:0]      c2, c1, c0;
    logic [POS_W-1:0]   end_index;
    logic [FB-1:0]      hi, mid, lo;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   owed_elements[$];
    int                 errors;

    function new();
      field_exp  = FIELD_EXP_RST;
      field_poly = FIELD_POLY_RST[FB:0];
      c2         = COEF_C2_RST[FB-1:0];
      c1         = COEF_C1_RST[FB-1:0];
      c0         = COEF_C0_RST[FB-1:0];
      end_index  = END_INDEX_RST;
      hi         = '0;
      mid        = '0;
      lo         = FB'(1);
      pos        = '0;
      errors     = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
      case (r)
        REG_FIELD_EXP:  field_exp  = v[EXP_W-1:0];
        REG_FIELD_POLY: field_poly = v[FB:0];
        REG_COEF_C2:    c2         = v[FB-1:0];
        REG_COEF_C1:    c1         = v[FB-1:0];
        REG_COEF_C0:    c0         = v[FB-1:0];
        REG_END_INDEX:  end_index  = v[POS_W-1:0];
        default: ;
      endcase
    endfunction

    // Field degree in use: clamped to 1..FB
    function int unsigned degree();
      if (field_exp < 1) return 1;
      if (field_exp > FB) return FB;
      return 32'(field_exp);
    endfunction

    // Shift-and-add multiply in GF(2^n); the x^n term of the polynomial is implied
    function logic [FB-1:0] gf_mul(logic [FB-1:0] a, logic [FB-1:0] b, int unsigned n);
      int unsigned mask, red, top, x, acc;
      mask = (32'd1 << n) - 1;
      red  = field_poly & mask;
      top  = 32'd1 << (n - 1);
      x    = a & mask;
      acc  = 0;
      for (int i = 0; i < n; i++) begin
        if (b[i]) acc ^= x;
        x = (x & top) ? (((x << 1) & mask) ^ red) : ((x << 1) & mask);
      end
      return acc[FB-1:0];
    endfunction

    // Advance the model on an accepted request
    function void note_request(action_t act, logic [POS_W-1:0] idx,
                               logic [FB-1:0] h, logic [FB-1:0] m, logic [FB-1:0] l);
      int unsigned n;
      logic [FB-1:0] mask;
      logic [FB-1:0] hh, mm, ll;
      n    = degree();
      mask = FB'((32'd1 << n) - 1);
      if (act == ACT_RESTART) begin
        pos = idx;
        hi  = h & mask;
        mid = m & mask;
        lo  = l & mask;
        return;
      end
      if (pos >= end_index) return;
      hh = hi & mask;
      mm = mid & mask;
      ll = lo & mask;
      if (hh == 0) owed_elements.push_back(pos);
      hi  = (mm ^ gf_mul(hh, c2, n)) & mask;
      mid = (ll ^ gf_mul(hh, c1, n)) & mask;
      lo  = gf_mul(hh, c0, n) & mask;
      pos = pos + 1'b1;
    endfunction

    function void check_element(logic [POS_W-1:0] got);
      logic [POS_W-1:0] want;
      if (owed_elements.size() == 0) begin
        errors++;
        $display("%0t: element_index expected none got %0d", $time, got);
        return;
      end
      want = owed_elements.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: element_index expected %0d got %0d", $time, want, got);
      end
    endfunction

    function int owed();
      return owed_elements.size();
    endfunction
  endclass

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  action_t               action      = ACT_STEP;
  logic [POS_W-1:0]      start_index = '0;
  logic [START_W-1:0]    start_high  = '0;
  logic [START_W-1:0]    start_mid   = '0;
  logic [START_W-1:0]    start_low   = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [POS_W-1:0]      element_index;
  logic                  cfg_write   = 1'b0;
  cfg_reg_t              cfg_index   = REG_FIELD_EXP;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  bit                    calm        = 1'b0;
  bit                    hold_req    = 1'b0;
  int                    stuck_cycles = 0;
  element_scoreboard     sb          = new();

  singer_set_recurrence_generator_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .start_index   (start_index),
    .start_high    (start_high),
    .start_mid     (start_mid),
    .start_low     (start_low),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .element_index (element_index),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [32:0] rand33();
    return {1'($urandom_range(0, 1)), 32'($urandom())};
  endfunction

  // Monitor both channels, update the model, and watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_request(action, start_index, start_high, start_mid, start_low);
      if (out_valid && !out_stall)
        sb.check_element(element_index);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    wait (!rst);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until accepted; maybe idle afterwards
  task automatic send_request(input action_t act, input logic [POS_W-1:0] idx,
                              input logic [15:0] h, input logic [15:0] m,
                              input logic [15:0] l);
    in_valid    <= 1'b1;
    action      <= act;
    start_index <= idx;
    start_high  <= h;
    start_mid   <= m;
    start_low   <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    sb.write_reg(r, v);
  endtask

  // Write all registers; bits above each register's width carry noise
  task automatic configure(input logic [4:0] n, input logic [16:0] poly,
                           input logic [15:0] k2, input logic [15:0] k1,
                           input logic [15:0] k0, input logic [32:0] last);
    logic [32:0] noise;
    noise = rand33();
    write_reg(REG_FIELD_EXP,  {noise[32:5], n});
    write_reg(REG_FIELD_POLY, {noise[32:17], poly});
    noise = rand33();
    write_reg(REG_COEF_C2,    {noise[32:16], k2});
    noise = rand33();
    write_reg(REG_COEF_C1,    {noise[32:16], k1});
    noise = rand33();
    write_reg(REG_COEF_C0,    {noise[32:16], k0});
    write_reg(REG_END_INDEX,  last);
    cfg_write <= 1'b0;
  endtask

  // Stop offering and wait for every owed element plus the pipeline tail
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Mostly steps, some restarts aimed at the start, the end and the top range
  task automatic run_random(input int count);
    logic [32:0] idx;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       idx = rand33();
          1:       idx = 33'($urandom_range(0, 300));
          2:       idx = sb.end_index - 33'($urandom_range(0, 40));
          default: idx = 33'd4294967296 + 33'($urandom_range(0, 65536));
        endcase
        send_request(ACT_RESTART, idx, 16'($urandom()), 16'($urandom()),
                     16'($urandom()));
      end else begin
        send_request(ACT_STEP, rand33(), 16'($urandom()), 16'($urandom()),
                     16'($urandom()));
      end
    end
  endtask

  initial begin
    logic [4:0]  n;
    logic [16:0] poly;
    logic [15:0] k2, k1, k0;
    logic [32:0] last;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: opening run from the reset vector
    send_request(ACT_STEP, '0, '0, '0, '0);
    send_request(ACT_STEP, '0, '0, '0, '0);
    send_request(ACT_STEP, '0, '0, '0, '0);
    // Restart at the top of the position range: past the end, nothing emitted
    send_request(ACT_RESTART, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(ACT_STEP, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Last position before the end emits, the next step is dead
    send_request(ACT_RESTART, END_INDEX_RST - 1'b1, '0, '0, '0);
    send_request(ACT_STEP, '0, '0, '0, '0);
    send_request(ACT_STEP, '0, '0, '0, '0);
    send_request(ACT_RESTART, '0, 16'hFFFF, '0, 16'h8000);
    send_request(ACT_STEP, '0, '0, '0, '0);
    send_request(ACT_STEP, '0, '0, '0, '0);
    drain();

    // Degree zero acts as one; zero constant coefficient; wide operands masked
    configure(5'd0, 17'h1FFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 33'd20);
    send_request(ACT_RESTART, '0, 16'hFFFE, 16'h0001, 16'hFFFF);
    repeat (4) send_request(ACT_STEP, '0, '0, '0, '0);
    drain();

    // Degree above the field width clamps; x^n bit clear; end index zero
    configure(5'd31, 17'h0002D, 16'd3, 16'd5, 16'd7, 33'd0);
    send_request(ACT_RESTART, '0, '0, '0, '0);
    send_request(ACT_STEP, '0, '0, '0, '0);
    send_request(ACT_STEP, '0, '0, '0, '0);
    drain();

    // Random phases, each with its own register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       n = 5'd16;
        1:       n = 5'd1;
        2:       n = 5'd3;
        3:       n = 5'd31;
        4:       n = 5'd0;
        default: n = ($urandom_range(0, 2) != 0) ? 5'($urandom_range(2, 6))
                                                  : 5'($urandom_range(0, 31));
      endcase
      poly = (p == 0) ? FIELD_POLY_RST[16:0] : 17'($urandom());
      k2   = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom());
      k1   = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom());
      k0   = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom());
      case (p % 4)
        0:       last = '1;
        1:       last = 33'($urandom_range(20, 400));
        2:       last = END_INDEX_RST;
        default: last = rand33();
      endcase
      configure(n, poly, k2, k1, k0, last);

      // Long result hold-off with a steady sender fills the output buffer
      if (p == HOLD_PHASE) begin
        calm     = 1'b1;
        hold_req = 1'b1;
      end
      if (p >= PHASES - 2) calm = 1'b1;
      run_random(PHASE_LEN);
      drain();
      if (p == HOLD_PHASE) calm = 1'b0;
    end

    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
